FILE: hdl/poqc_pkg.sv
// shared constants, beat structs and control types for the opening-proof block
package poqc_pkg;

    localparam int FIELD_BITS   = 32;
    localparam int COUNT_BITS   = 16;
    localparam int DEG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int BIT_IDX_BITS = $clog2(FIELD_BITS);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODULUS    = 2'd0,
        CFG_SRS_BASE   = 2'd1,
        CFG_MAX_DEGREE = 2'd2
    } t_cfg_idx;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_DEG_ZERO  = 2'd1;
    localparam logic [1:0] STS_DEG_LIMIT = 2'd2;

    typedef struct packed {
        logic [FIELD_BITS-1:0] coeff;
        logic [FIELD_BITS-1:0] point_z;
        logic                  last;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_BITS-1:0] q_commit;
        logic [FIELD_BITS-1:0] value_y;
        logic [FIELD_BITS-1:0] point_out;
        logic [1:0]            status;
    } t_out_beat;

    typedef struct packed {
        logic                    load;
        logic                    red_step;
        logic                    mul_step;
        logic                    finish;
        logic [BIT_IDX_BITS-1:0] bit_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_stat;

endpackage

FILE: hdl/poqc_ctrl.sv
// sequencer: reduce pass, multiply pass, finish step and output valid
module poqc_ctrl
    import poqc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REDUCE = 4'b0010,
        ST_MULT   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [BIT_IDX_BITS-1:0] r_bit, n_bit;
    logic                    r_out_valid, n_out_valid;
    logic                    out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_bit         = r_bit;
        o_cmd         = '0;
        o_cmd.bit_idx = r_bit;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit      = BIT_IDX_BITS'(FIELD_BITS - 1);
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.red_step = 1'b1;
                if (r_bit == '0) begin
                    n_bit   = BIT_IDX_BITS'(FIELD_BITS - 1);
                    n_state = ST_MULT;
                end else begin
                    n_bit = r_bit - BIT_IDX_BITS'(1);
                end
            end
            ST_MULT: begin
                o_cmd.mul_step = 1'b1;
                if (r_bit == '0) begin
                    n_state = ST_FINISH;
                end else begin
                    n_bit = r_bit - BIT_IDX_BITS'(1);
                end
            end
            ST_FINISH: begin
                // a result beat waits for room in the output register
                if (!i_stat.last || out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.finish && i_stat.last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/poqc_datapath.sv
// config registers, bit-serial mod reducers, bit-serial mod multipliers, result register
module poqc_datapath
    import poqc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [FIELD_BITS-1:0]   i_cfg_data,
    input  t_in_beat                i_in_data,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    output t_out_beat               o_out_data
);

    localparam int LANES    = 5;
    localparam int LN_COEFF = 0;
    localparam int LN_POINT = 1;
    localparam int LN_SRS   = 2;
    localparam int LN_RUN   = 3;
    localparam int LN_ACC   = 4;

    function automatic logic [FIELD_BITS-1:0] add_mod(
        input logic [FIELD_BITS-1:0] a,
        input logic [FIELD_BITS-1:0] b,
        input logic [FIELD_BITS-1:0] p
    );
        logic [FIELD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[FIELD_BITS-1:0];
    endfunction

    // one restoring step: rem = (2*rem + bit) mod p
    function automatic logic [FIELD_BITS-1:0] shift_mod(
        input logic [FIELD_BITS-1:0] rem,
        input logic                  bit_in,
        input logic [FIELD_BITS-1:0] p
    );
        logic [FIELD_BITS:0] s;
        s = {rem, bit_in};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[FIELD_BITS-1:0];
    endfunction

    logic [FIELD_BITS-1:0] r_modulus;
    logic [FIELD_BITS-1:0] r_srs_base;
    logic [DEG_BITS-1:0]   r_max_degree;
    logic [FIELD_BITS-1:0] r_run;
    logic [FIELD_BITS-1:0] r_acc;
    logic [FIELD_BITS-1:0] r_held;
    logic [COUNT_BITS-1:0] r_count;

    logic [FIELD_BITS-1:0] r_coeff;
    logic [FIELD_BITS-1:0] r_z_in;
    logic                  r_first;
    logic                  r_last;
    logic [FIELD_BITS-1:0] r_rem [LANES];
    logic [FIELD_BITS-1:0] r_mul [2];
    t_out_beat             r_out;

    logic [FIELD_BITS-1:0] p_eff;
    logic [FIELD_BITS-1:0] lane_src [LANES];
    logic [FIELD_BITS-1:0] mul_a [2];
    logic [FIELD_BITS-1:0] mul_b [2];
    logic [FIELD_BITS-1:0] run_new;
    logic [FIELD_BITS-1:0] acc_new;
    logic [1:0]            status;

    // a modulus of 0 or 1 acts as 1
    assign p_eff = (r_modulus[FIELD_BITS-1:1] == '0) ? FIELD_BITS'(1) : r_modulus;

    assign lane_src[LN_COEFF] = r_coeff;
    assign lane_src[LN_POINT] = r_first ? r_z_in : r_held;
    assign lane_src[LN_SRS]   = r_srs_base;
    assign lane_src[LN_RUN]   = r_run;
    assign lane_src[LN_ACC]   = r_acc;

    // z * r and acc * s
    assign mul_a[0] = r_rem[LN_POINT];
    assign mul_b[0] = r_rem[LN_RUN];
    assign mul_a[1] = r_rem[LN_ACC];
    assign mul_b[1] = r_rem[LN_SRS];

    assign run_new = add_mod(r_rem[LN_COEFF], r_mul[0], p_eff);
    assign acc_new = add_mod(r_mul[1], run_new, p_eff);

    always_comb begin
        if (&r_count) begin
            status = STS_DEG_LIMIT;
        end else if (r_count == '0) begin
            status = STS_DEG_ZERO;
        end else if ((r_count - COUNT_BITS'(1)) > r_max_degree) begin
            status = STS_DEG_LIMIT;
        end else begin
            status = STS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus    <= FIELD_BITS'(32'd2147483647);
            r_srs_base   <= FIELD_BITS'(1);
            r_max_degree <= '1;
            r_run        <= '0;
            r_acc        <= '0;
            r_held       <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODULUS:    r_modulus    <= i_cfg_data;
                    CFG_SRS_BASE:   r_srs_base   <= i_cfg_data;
                    CFG_MAX_DEGREE: r_max_degree <= i_cfg_data[DEG_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_held <= r_rem[LN_POINT];
                if (r_last) begin
                    r_run   <= '0;
                    r_acc   <= '0;
                    r_count <= '0;
                end else begin
                    r_run <= run_new;
                    r_acc <= acc_new;
                    if (!(&r_count)) begin
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_coeff <= i_in_data.coeff;
            r_z_in  <= i_in_data.point_z;
            r_last  <= i_in_data.last;
            r_first <= (r_count == '0);
            r_mul[0] <= '0;
            r_mul[1] <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_rem[i] <= '0;
            end
        end
        if (i_cmd.red_step) begin
            for (int i = 0; i < LANES; i++) begin
                r_rem[i] <= shift_mod(r_rem[i], lane_src[i][i_cmd.bit_idx], p_eff);
            end
        end
        if (i_cmd.mul_step) begin
            for (int k = 0; k < 2; k++) begin
                if (mul_b[k][i_cmd.bit_idx]) begin
                    r_mul[k] <= add_mod(add_mod(r_mul[k], r_mul[k], p_eff), mul_a[k], p_eff);
                end else begin
                    r_mul[k] <= add_mod(r_mul[k], r_mul[k], p_eff);
                end
            end
        end
        if (i_cmd.finish && r_last) begin
            r_out.q_commit  <= (status == STS_OK) ? r_rem[LN_ACC] : '0;
            r_out.value_y   <= run_new;
            r_out.point_out <= r_rem[LN_POINT];
            r_out.status    <= status;
        end
    end

    assign o_stat.last = r_last;
    assign o_out_data  = r_out;

endmodule

FILE: hdl/poly_open_quotient_commit.sv
// Streaming opening proof: each coefficient (highest degree first) is reduced mod p and
// folded by synthetic division r = c + z*r, the quotient coefficients are Horner-accumulated
// against the base s, and the beat marked last returns the quotient commitment, P(z), z mod p
// and a status (ok, degree zero, degree over limit). Each coefficient goes through an accept
// step, a bit-serial pass that reduces the coefficient, z, s and the running state mod p in
// parallel lanes, a pass of two bit-serial modular multipliers (z*r and acc*s) and a finish
// step. The input stalls while a coefficient is in work; the result sits in an output
// register so the next polynomial may start while it waits. The configuration port is
// always ready and must be written only while the block is idle; the block does not check.
module poly_open_quotient_commit
    import poqc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [FIELD_BITS-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_beat                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_beat               o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    poqc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    poqc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule
